/* rtl/vcfm_pkg.sv */
// Package for the valve command frame matcher: frame bytes, kind codes,
// window and match types, and the command frame compare function.
// No dependencies.
package vcfm_pkg;

    localparam int WinDepth = 8;
    localparam int CmdLen   = 7;
    localparam int PairLen  = 8;

    localparam logic [7:0] BYTE_HEADER = 8'hBB;
    localparam logic [7:0] BYTE_CMD    = 8'h01;
    localparam logic [7:0] BYTE_PAIR   = 8'h02;
    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_LF     = 8'h0A;

    localparam logic [1:0] KIND_OPEN  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;
    localparam logic [1:0] KIND_PAIR  = 2'd3;

    localparam logic [1:0] REG_PAIRING_MODE = 2'd0;

    typedef logic [WinDepth-1:0][7:0] window_t;
    typedef logic [CmdLen-1:0][7:0]   cmd_frame_t;
    typedef logic [3:0]               fill_t;

    // Byte 0 is the first byte on the wire.
    localparam cmd_frame_t FRAME_OPEN  =
        {BYTE_LF, BYTE_CR, 8'h03, 8'h01, BYTE_CMD, BYTE_CMD, BYTE_HEADER};
    localparam cmd_frame_t FRAME_CLOSE =
        {BYTE_LF, BYTE_CR, 8'h04, 8'h02, BYTE_CMD, BYTE_CMD, BYTE_HEADER};
    localparam cmd_frame_t FRAME_STOP  =
        {BYTE_LF, BYTE_CR, 8'h02, 8'h00, BYTE_CMD, BYTE_CMD, BYTE_HEADER};

    typedef struct packed {
        logic        hit;
        logic [1:0]  kind;
        logic [15:0] id;
        fill_t       drop;
    } match_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] kind;
    } cmd_hit_t;

    function automatic cmd_hit_t cmd_compare(input cmd_frame_t f);
        cmd_hit_t r;
        r.hit  = 1'b1;
        r.kind = KIND_OPEN;
        if (f == FRAME_OPEN) begin
            r.kind = KIND_OPEN;
        end else if (f == FRAME_CLOSE) begin
            r.kind = KIND_CLOSE;
        end else if (f == FRAME_STOP) begin
            r.kind = KIND_STOP;
        end else begin
            r.hit = 1'b0;
        end
        return r;
    endfunction

endpackage

/* rtl/valve_command_frame_matcher.sv */
// Top level of the valve command frame matcher: byte stream in, recognized
// frames out, APB register for pairing mode. Depends on vcfm_pkg, vcfm_match.
//
// Takes one received byte per transfer and reports each recognized open,
// close, stop or pairing frame as one output transfer: tuser carries the
// kind, tdata the pairing ID and the running frame count. An input byte is
// taken every cycle while s_axis_tready is high; its result, if any, is shown
// next cycle from an output register. The window, fill and frame count update
// in the same cycle as the input transfer through a single compare-and-shift
// stage, so s_axis_tready drops only while a result waits and m_axis_tready
// is low. Write pairing_mode only while no bytes are in flight.
module valve_command_frame_matcher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] pair_id, [23:16] frame_total
    output logic [1:0]  m_axis_tuser,   // [1:0] frame_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    vcfm_pkg::window_t window_reg, window_next, window_app;
    vcfm_pkg::fill_t   fill_reg, fill_next, fill_app;
    logic [7:0]        count_reg, count_next;
    logic              mode_reg, mode_next;
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_kind_reg, m_kind_next;
    logic [15:0]       m_id_reg, m_id_next;
    logic [7:0]        m_total_reg, m_total_next;
    logic              in_xfer;
    logic              cfg_write;
    vcfm_pkg::match_t  match;

    assign pready        = 1'b1;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_write     = psel && penable && pwrite && pready &&
                           (paddr == vcfm_pkg::REG_PAIRING_MODE);
    assign prdata        = (paddr == vcfm_pkg::REG_PAIRING_MODE) ?
                           {31'd0, mode_reg} : 32'd0;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tdata  = {m_total_reg, m_id_reg};

    // Append the new byte; a full window drops its oldest byte first.
    always_comb begin
        window_app = window_reg;
        if (fill_reg[3]) begin
            window_app = {s_axis_tdata, window_reg[7:1]};
            fill_app   = 4'(vcfm_pkg::WinDepth);
        end else begin
            window_app[fill_reg[2:0]] = s_axis_tdata;
            fill_app                  = fill_reg + 4'd1;
        end
    end

    vcfm_match u_match (
        .win_i          (window_app),
        .fill_i         (fill_app),
        .pairing_mode_i (mode_reg),
        .match_o        (match)
    );

    always_comb begin
        window_next  = window_reg;
        fill_next    = fill_reg;
        count_next   = count_reg;
        mode_next    = cfg_write ? pwdata[0] : mode_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_kind_next  = m_kind_reg;
        m_id_next    = m_id_reg;
        m_total_next = m_total_reg;
        if (in_xfer) begin
            window_next = window_app >> {match.drop, 3'b000};
            fill_next   = fill_app - match.drop;
            if (match.hit) begin
                count_next   = count_reg + 8'd1;
                m_valid_next = 1'b1;
                m_kind_next  = match.kind;
                m_id_next    = match.id;
                m_total_next = count_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= '0;
            fill_reg    <= '0;
            count_reg   <= '0;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            window_reg  <= window_next;
            fill_reg    <= fill_next;
            count_reg   <= count_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_kind_reg  <= m_kind_next;
        m_id_reg    <= m_id_next;
        m_total_reg <= m_total_next;
    end

endmodule

/* rtl/vcfm_match.sv */
// Frame recognizer for the valve command frame matcher: checks the window
// after the new byte is appended and decides the result and bytes to drop.
// Depends on vcfm_pkg.
module vcfm_match (
    input  vcfm_pkg::window_t win_i,
    input  vcfm_pkg::fill_t   fill_i,
    input  logic              pairing_mode_i,
    output vcfm_pkg::match_t  match_o
);

    vcfm_pkg::cmd_hit_t hit_front;
    vcfm_pkg::cmd_hit_t hit_back;
    logic               pair_ok;
    logic [7:0]         pair_sum;

    assign hit_front = vcfm_pkg::cmd_compare(win_i[6:0]);
    assign hit_back  = vcfm_pkg::cmd_compare(win_i[7:1]);
    assign pair_sum  = win_i[1] + win_i[2] + win_i[3] + win_i[4];
    assign pair_ok   = (win_i[0] == vcfm_pkg::BYTE_HEADER) &&
                       (win_i[1] == vcfm_pkg::BYTE_PAIR) &&
                       (win_i[2] == vcfm_pkg::BYTE_PAIR) &&
                       (win_i[6] == vcfm_pkg::BYTE_CR) &&
                       (win_i[7] == vcfm_pkg::BYTE_LF) &&
                       (pair_sum == win_i[5]);

    always_comb begin
        match_o.hit  = 1'b0;
        match_o.kind = vcfm_pkg::KIND_OPEN;
        match_o.id   = 16'h0000;
        match_o.drop = 4'd0;
        if (!pairing_mode_i) begin
            if (fill_i == 4'(vcfm_pkg::CmdLen)) begin
                match_o.hit  = hit_front.hit;
                match_o.kind = hit_front.kind;
                match_o.drop = hit_front.hit ? 4'(vcfm_pkg::CmdLen) : 4'd1;
            end else if (fill_i == 4'(vcfm_pkg::WinDepth)) begin
                if (hit_front.hit) begin
                    match_o.hit  = 1'b1;
                    match_o.kind = hit_front.kind;
                    match_o.drop = 4'(vcfm_pkg::CmdLen);
                end else if (hit_back.hit) begin
                    match_o.hit  = 1'b1;
                    match_o.kind = hit_back.kind;
                    match_o.drop = 4'(vcfm_pkg::WinDepth);
                end else begin
                    match_o.drop = 4'd2;
                end
            end
        end else if (fill_i == 4'(vcfm_pkg::PairLen)) begin
            if (hit_front.hit) begin
                match_o.hit  = 1'b1;
                match_o.kind = hit_front.kind;
                match_o.drop = 4'(vcfm_pkg::CmdLen);
            end else if (pair_ok) begin
                match_o.hit  = 1'b1;
                match_o.kind = vcfm_pkg::KIND_PAIR;
                match_o.id   = {win_i[3], win_i[4]};
                match_o.drop = 4'(vcfm_pkg::PairLen);
            end else begin
                match_o.drop = 4'd1;
            end
        end
    end

endmodule

/* rtl/vcfm_checker.sv */
// Port-level checker for the valve command frame matcher, bound to the top
// level. Depends on vcfm_pkg and valve_command_frame_matcher.
module vcfm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic       out_xfer;
    logic       seen_reg;
    logic [7:0] last_total_reg;

    assign out_xfer = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (out_xfer) begin
            seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_xfer) begin
            last_total_reg <= m_axis_tdata[23:16];
        end
    end

    a_no_output_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("stalled result dropped");

    a_stall_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result register is blocked");

    a_total_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_xfer && seen_reg) |-> (m_axis_tdata[23:16] == last_total_reg + 8'd1))
        else $error("frame count skipped or repeated");

    a_cmd_zero_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser != vcfm_pkg::KIND_PAIR))
            |-> (m_axis_tdata[15:0] == 16'h0000))
        else $error("command frame carries a nonzero ID");

endmodule

bind valve_command_frame_matcher vcfm_checker u_vcfm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* tb/sv/vcfm_frame_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the valve command frame matcher: tracks the byte window, the pairing mode
// register and the frame count, then compares every output transfer field by field.
// Depends on vcfm_pkg.
module vcfm_frame_checker
    import vcfm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          fail_count,
    output int          frames_checked,
    output int          outstanding
);

    localparam logic [1:0] MODE_ADDR = 2'(4 * REG_PAIRING_MODE);
    localparam logic [1:0] CMD_KINDS [3] = '{KIND_OPEN, KIND_CLOSE, KIND_STOP};
    localparam int MAX_PRINTS = 100;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] id;
        logic [7:0]  total;
    } frame_result_t;

    frame_result_t pending_frames[$];
    logic [7:0]    win_bytes [WinDepth];
    int            win_fill;
    logic [7:0]    frame_total;
    logic          pairing_on;
    int            mismatches = 0;
    int            frames_seen = 0;

    assign fail_count     = mismatches;
    assign frames_checked = frames_seen;

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    function automatic cmd_frame_t cmd_pattern(input logic [1:0] kind);
        case (kind)
            KIND_OPEN:  return FRAME_OPEN;
            KIND_CLOSE: return FRAME_CLOSE;
            default:    return FRAME_STOP;
        endcase
    endfunction

    function automatic void drop_oldest(input int n);
        if (n >= win_fill) begin
            win_fill = 0;
        end else begin
            for (int i = 0; i < win_fill - n; i++) begin
                win_bytes[i] = win_bytes[i + n];
            end
            win_fill = win_fill - n;
        end
    endfunction

    function automatic bool_cmd_match(input logic [1:0] kind);
        cmd_frame_t pat;
        pat = cmd_pattern(kind);
        for (int j = 0; j < CmdLen; j++) begin
            if (win_bytes[j] != pat[j]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Append one byte, then scan the window until it is shorter than the check length.
    function automatic void shift_in_byte(input logic [7:0] rx);
        int            need;
        int            consume;
        bit            hit;
        bit            reported;
        logic [1:0]    kind;
        logic [15:0]   id;
        logic [7:0]    crc;
        frame_result_t rec;
        need = pairing_on ? PairLen : CmdLen;
        if (win_fill >= WinDepth) drop_oldest(1);
        win_bytes[win_fill] = rx;
        win_fill++;
        reported = 1'b0;
        while (win_fill >= need) begin
            hit     = 1'b0;
            consume = 1;
            kind    = KIND_OPEN;
            id      = '0;
            for (int k = 0; k < 3; k++) begin
                if (!hit && bool_cmd_match(CMD_KINDS[k])) begin
                    hit     = 1'b1;
                    kind    = CMD_KINDS[k];
                    consume = CmdLen;
                end
            end
            if (!hit && pairing_on) begin
                crc = win_bytes[1] + win_bytes[2] + win_bytes[3] + win_bytes[4];
                if (win_bytes[0] == BYTE_HEADER && win_bytes[1] == BYTE_PAIR &&
                    win_bytes[2] == BYTE_PAIR && win_bytes[6] == BYTE_CR &&
                    win_bytes[7] == BYTE_LF && crc == win_bytes[5]) begin
                    hit     = 1'b1;
                    kind    = KIND_PAIR;
                    id      = {win_bytes[3], win_bytes[4]};
                    consume = PairLen;
                end
            end
            drop_oldest(consume);
            if (hit) begin
                frame_total = frame_total + 8'd1;
                if (!reported) begin
                    rec.kind  = kind;
                    rec.id    = id;
                    rec.total = frame_total;
                    pending_frames.push_back(rec);
                    reported = 1'b1;
                end
            end
        end
    endfunction

    always @(posedge aclk) begin
        frame_result_t got;
        frame_result_t want;
        if (!aresetn) begin
            win_fill    = 0;
            frame_total = '0;
            pairing_on  = 1'b0;
            pending_frames.delete();
            foreach (win_bytes[i]) win_bytes[i] = '0;
        end else begin
            if (psel && penable && pready && paddr == MODE_ADDR) begin
                if (pwrite) begin
                    pairing_on = pwdata[0];
                end else if (prdata !== {31'b0, pairing_on}) begin
                    report_mismatch($sformatf("pairing_mode read %h, want %0d",
                                              prdata, pairing_on));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                shift_in_byte(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind  = m_axis_tuser;
                got.id    = m_axis_tdata[15:0];
                got.total = m_axis_tdata[23:16];
                if (pending_frames.size() == 0) begin
                    report_mismatch($sformatf("unexpected frame kind %0d id %h total %0d",
                                              got.kind, got.id, got.total));
                end else begin
                    want = pending_frames.pop_front();
                    frames_seen++;
                    if (got.kind !== want.kind) begin
                        report_mismatch($sformatf("frame_kind %0d, want %0d",
                                                  got.kind, want.kind));
                    end
                    if (got.id !== want.id) begin
                        report_mismatch($sformatf("pair_id %h, want %h", got.id, want.id));
                    end
                    if (got.total !== want.total) begin
                        report_mismatch($sformatf("frame_total %0d, want %0d",
                                                  got.total, want.total));
                    end
                end
            end
        end
        outstanding <= pending_frames.size();
    end

endmodule

/* tb/sv/tb_valve_command_frame_matcher.sv */
`timescale 1ns / 1ps
// Top of the frame matcher testbench: clock, reset, byte stimulus, output stalls and
// pairing mode writes. Depends on vcfm_pkg, vcfm_frame_checker and the block itself.
module tb_valve_command_frame_matcher;
    import vcfm_pkg::*;

    localparam logic [1:0] MODE_ADDR = 2'(4 * REG_PAIRING_MODE);
    localparam logic [1:0] CMD_KINDS [3] = '{KIND_OPEN, KIND_CLOSE, KIND_STOP};
    localparam int ITEM_TARGET  = 1950;
    localparam int TAIL_BYTES   = 150;
    localparam int MAX_PHASES   = 60;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 2000;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int         fail_count;
    int         frames_checked;
    int         outstanding;
    int         stall_cycles = 0;
    int         bytes_sent = 0;
    int         send_gap_pct = 0;
    int         sink_stall_pct = 0;
    logic [7:0] wire_bytes[$];

    valve_command_frame_matcher i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    vcfm_frame_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .frames_checked (frames_checked),
        .outstanding    (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Hold off the result channel in random bursts.
    initial begin
        forever begin
            @(posedge aclk);
            if (sink_stall_pct != 0 && $urandom_range(1, 100) <= sink_stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_queued();
        foreach (wire_bytes[i]) send_byte(wire_bytes[i]);
        wire_bytes.delete();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MODE_ADDR;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_mode(input logic mode_on);
        logic [31:0] w;
        w    = $urandom();
        w[0] = mode_on;
        apb_access(1'b1, w);
        apb_access(1'b0, '0);
    endtask

    function automatic void queue_cmd(input logic [1:0] kind);
        cmd_frame_t pat;
        case (kind)
            KIND_OPEN:  pat = FRAME_OPEN;
            KIND_CLOSE: pat = FRAME_CLOSE;
            default:    pat = FRAME_STOP;
        endcase
        for (int j = 0; j < CmdLen; j++) wire_bytes.push_back(pat[j]);
    endfunction

    function automatic void queue_pairing(input logic [15:0] id);
        logic [7:0] crc;
        crc = BYTE_PAIR + BYTE_PAIR + id[15:8] + id[7:0];
        wire_bytes.push_back(BYTE_HEADER);
        wire_bytes.push_back(BYTE_PAIR);
        wire_bytes.push_back(BYTE_PAIR);
        wire_bytes.push_back(id[15:8]);
        wire_bytes.push_back(id[7:0]);
        wire_bytes.push_back(crc);
        wire_bytes.push_back(BYTE_CR);
        wire_bytes.push_back(BYTE_LF);
    endfunction

    function automatic logic [15:0] pick_id();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 6))
            0:       return BYTE_HEADER;
            1:       return BYTE_CMD;
            2:       return BYTE_PAIR;
            3:       return BYTE_CR;
            4:       return BYTE_LF;
            5:       return 8'h00;
            default: return 8'hFF;
        endcase
    endfunction

    // Mostly clean frames; the rest are corrupted, cut short or plain noise.
    function automatic void queue_segment(input logic mode_on);
        int r;
        int cut;
        r = $urandom_range(0, 99);
        if (r < 90) begin
            if ($urandom_range(0, mode_on ? 2 : 7) == 0) begin
                queue_pairing(pick_id());
            end else begin
                queue_cmd(CMD_KINDS[$urandom_range(0, 2)]);
            end
            if (r >= 80) begin
                cut = $urandom_range(1, wire_bytes.size() - 1);
                repeat (cut) void'(wire_bytes.pop_back());
            end else if (r >= 72) begin
                wire_bytes[$urandom_range(0, wire_bytes.size() - 1)] = noise_byte();
            end
        end else begin
            repeat ($urandom_range(1, 6)) wire_bytes.push_back(noise_byte());
        end
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 15;
            default: return 35;
        endcase
    endfunction

    task automatic run_phase(input logic mode_on, input bit idling);
        write_mode(mode_on);
        send_gap_pct   = idling ? pick_pct() : 0;
        sink_stall_pct = idling ? pick_pct() : 0;
        repeat ($urandom_range(15, 30)) begin
            queue_segment(mode_on);
            send_queued();
        end
        // Leave seven bytes held so the next mode switch sees a nearly full window.
        if (mode_on && $urandom_range(0, 1) == 1) begin
            if ($urandom_range(0, 1) == 1) begin
                queue_cmd(CMD_KINDS[$urandom_range(0, 2)]);
            end else begin
                repeat (CmdLen) wire_bytes.push_back(noise_byte());
            end
            send_queued();
        end
        drain();
    endtask

    initial begin
        int phase;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        queue_cmd(KIND_OPEN);
        queue_cmd(KIND_CLOSE);
        queue_cmd(KIND_STOP);
        send_queued();
        drain();
        write_mode(1'b1);
        queue_pairing(16'hFFFF);
        send_queued();
        drain();

        phase = 0;
        while (phase < MAX_PHASES && bytes_sent < ITEM_TARGET - TAIL_BYTES) begin
            run_phase(phase[0], 1'b1);
            phase++;
        end
        run_phase(1'($urandom_range(0, 1)), 1'b0);

        $display("Sent %0d bytes over %0d register phases, pairing mode on and off",
                 bytes_sent, phase + 2);
        $display("Compared %0d recognized frames, frame count wrapped %0d times",
                 frames_checked, frames_checked / 256);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
